@@ hw/rtl/dfx_pkg.sv @@
// shared types and constants for the diagnostic frame deframer
`timescale 1ns / 1ps
package dfx_pkg;

  localparam int unsigned MaxFrameLen = 255;

  localparam logic [7:0] Ovh8  = 8'd3;
  localparam logic [7:0] Ovh16 = 8'd4;

  typedef enum logic [2:0] {
    PH_ADDR   = 3'd0,
    PH_HEAD   = 3'd1,
    PH_LENLO  = 3'd2,
    PH_BODY8  = 3'd3,
    PH_BODY16 = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CHKERR  = 2'd1,
    ST_INVALID = 2'd2,
    ST_INSUFF  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] pbyte;
    logic [7:0] pidx;
    logic [7:0] addr;
    logic [7:0] cnt;
    status_t    status;
    logic [7:0] chk;
  } result_t;

endpackage

@@ hw/rtl/dfx_parser.sv @@
// frame parse state and per-byte result logic
`timescale 1ns / 1ps
module dfx_parser #(
  parameter int unsigned MAX_FRAME_LEN = dfx_pkg::MaxFrameLen
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       byte_value,
  input  logic             eob,
  input  logic             frame_mode,
  output logic             res_valid,
  output dfx_pkg::result_t res
);

  localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

  dfx_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       inv_r, inv_nxt;

  logic       status_hit;
  logic [7:0] ovh;
  logic [7:0] seen_inc;
  logic [7:0] body_cnt;
  logic       bad3;
  logic       bad4;

  assign ovh      = (phase_r == dfx_pkg::PH_BODY8) ? dfx_pkg::Ovh8 : dfx_pkg::Ovh16;
  assign seen_inc = seen_r + 8'd1;
  assign body_cnt = len_r - ovh;
  assign bad3 = (byte_value == 8'd0) || (byte_value > MaxLen) ||
                (byte_value <= dfx_pkg::Ovh8);
  assign bad4 = (byte_value == 8'd0) || (byte_value > MaxLen) ||
                (byte_value <= dfx_pkg::Ovh16);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      dfx_pkg::PH_HEAD: begin
        if (frame_mode) begin
          phase_nxt = (byte_value != 8'd0 || eob) ? dfx_pkg::PH_ADDR : dfx_pkg::PH_LENLO;
        end else begin
          phase_nxt = eob ? dfx_pkg::PH_ADDR : dfx_pkg::PH_BODY8;
        end
      end
      dfx_pkg::PH_LENLO: begin
        phase_nxt = eob ? dfx_pkg::PH_ADDR : dfx_pkg::PH_BODY16;
      end
      dfx_pkg::PH_BODY8, dfx_pkg::PH_BODY16: begin
        phase_nxt = status_hit ? dfx_pkg::PH_ADDR : phase_r;
      end
      default: begin
        phase_nxt = eob ? dfx_pkg::PH_ADDR : dfx_pkg::PH_HEAD;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    addr_nxt   = addr_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    xor_nxt    = xor_r;
    inv_nxt    = inv_r;
    status_hit = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    res.addr   = addr_r;
    case (phase_r)
      dfx_pkg::PH_HEAD: begin
        xor_nxt  = xor_r ^ byte_value;
        seen_nxt = 8'd2;
        if (frame_mode) begin
          if (byte_value != 8'd0) begin
            res_valid  = 1'b1;
            res.kind   = dfx_pkg::KIND_STATUS;
            res.status = dfx_pkg::ST_INVALID;
          end else if (eob) begin
            res_valid  = 1'b1;
            res.kind   = dfx_pkg::KIND_STATUS;
            res.status = dfx_pkg::ST_INSUFF;
          end
        end else begin
          len_nxt = byte_value;
          inv_nxt = bad3;
          if (eob) begin
            res_valid  = 1'b1;
            res.kind   = dfx_pkg::KIND_STATUS;
            res.status = dfx_pkg::ST_INSUFF;
            res.cnt    = bad3 ? 8'd0 : byte_value - dfx_pkg::Ovh8;
          end
        end
      end
      dfx_pkg::PH_LENLO: begin
        xor_nxt  = xor_r ^ byte_value;
        seen_nxt = 8'd3;
        len_nxt  = byte_value;
        inv_nxt  = bad4;
        if (eob) begin
          res_valid  = 1'b1;
          res.kind   = dfx_pkg::KIND_STATUS;
          res.status = dfx_pkg::ST_INSUFF;
          res.cnt    = bad4 ? 8'd0 : byte_value - dfx_pkg::Ovh16;
        end
      end
      dfx_pkg::PH_BODY8, dfx_pkg::PH_BODY16: begin
        if (inv_r) begin
          seen_nxt = seen_inc;
          if (seen_inc >= ovh + 8'd1) begin
            status_hit = 1'b1;
            res_valid  = 1'b1;
            res.kind   = dfx_pkg::KIND_STATUS;
            res.status = dfx_pkg::ST_INVALID;
          end else if (eob) begin
            status_hit = 1'b1;
            res_valid  = 1'b1;
            res.kind   = dfx_pkg::KIND_STATUS;
            res.status = dfx_pkg::ST_INSUFF;
          end
        end else if (seen_r == len_r - 8'd1) begin
          // checksum byte
          status_hit = 1'b1;
          res_valid  = 1'b1;
          res.kind   = dfx_pkg::KIND_STATUS;
          res.cnt    = body_cnt;
          res.chk    = xor_r;
          res.status = (byte_value == xor_r) ? dfx_pkg::ST_OK : dfx_pkg::ST_CHKERR;
        end else if (eob) begin
          status_hit = 1'b1;
          res_valid  = 1'b1;
          res.kind   = dfx_pkg::KIND_STATUS;
          res.cnt    = body_cnt;
          res.status = dfx_pkg::ST_INSUFF;
        end else begin
          seen_nxt  = seen_inc;
          xor_nxt   = xor_r ^ byte_value;
          res_valid = 1'b1;
          res.kind  = dfx_pkg::KIND_PAYLOAD;
          res.pbyte = byte_value;
          res.pidx  = seen_r - (ovh - 8'd1);
          res.cnt   = body_cnt;
        end
      end
      default: begin
        addr_nxt = byte_value;
        xor_nxt  = byte_value;
        seen_nxt = 8'd1;
        len_nxt  = 8'd0;
        inv_nxt  = 1'b0;
        res.addr = byte_value;
        if (eob) begin
          res_valid  = 1'b1;
          res.kind   = dfx_pkg::KIND_STATUS;
          res.status = dfx_pkg::ST_INSUFF;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dfx_pkg::PH_ADDR;
      addr_r  <= 8'd0;
      len_r   <= 8'd0;
      seen_r  <= 8'd0;
      xor_r   <= 8'd0;
      inv_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      xor_r   <= xor_nxt;
      inv_r   <= inv_nxt;
    end
  end

endmodule

@@ hw/rtl/diag_frame_deframer_xor_check_top.sv @@
// top level of the diagnostic frame deframer with xor checksum
//
//   channel | dir | handshake         | payload
//   in_     | in  | in_valid/in_stall | in_byte_value, in_end_of_buffer
//   out_    | out | out_valid/out_stall | kind, byte, index, address, count,
//           |     |                   | status, computed check
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_frame_mode
//
// one byte per cycle unless a stalled result blocks the input; from input to result
// a byte passes the input register, then parse logic into the output register
// a byte that gives no result never waits on the output side
// reset is synchronous and active low; it clears parse state and frame_mode
// a stalled result holds the output register, and the input register then
// stalls the input only when its byte has a result to deliver
`timescale 1ns / 1ps
module diag_frame_deframer_xor_check_top #(
  parameter int unsigned MAX_FRAME_LEN = dfx_pkg::MaxFrameLen
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_end_of_buffer,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_result_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_payload_index,
  output logic [7:0] out_frame_address,
  output logic [7:0] out_data_count,
  output logic [1:0] out_frame_status,
  output logic [7:0] out_computed_check,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_frame_mode
);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_eob_r;
  logic             mode_r;
  logic             out_valid_r;
  dfx_pkg::result_t out_res_r;

  logic             res_valid;
  dfx_pkg::result_t res;
  logic             out_free;
  logic             s1_go;
  logic             in_take;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!res_valid || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  dfx_parser #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_go),
    .byte_value (s1_byte_r),
    .eob        (s1_eob_r),
    .frame_mode (mode_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_frame_mode;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte_value;
      s1_eob_r  <= in_end_of_buffer;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_res_r.kind;
  assign out_payload_byte   = out_res_r.pbyte;
  assign out_payload_index  = out_res_r.pidx;
  assign out_frame_address  = out_res_r.addr;
  assign out_data_count     = out_res_r.cnt;
  assign out_frame_status   = out_res_r.status;
  assign out_computed_check = out_res_r.chk;

`ifndef SYNTHESIS
  a_payload_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind == dfx_pkg::KIND_PAYLOAD |->
      out_res_r.status == dfx_pkg::ST_OK)
    else $error("payload transaction carries a nonzero status");

  a_payload_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind == dfx_pkg::KIND_PAYLOAD |->
      out_res_r.pidx < out_res_r.cnt)
    else $error("payload index not below data count");

  a_check_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status == dfx_pkg::ST_INVALID ||
                    out_res_r.status == dfx_pkg::ST_INSUFF) |->
      out_res_r.chk == 8'd0)
    else $error("computed check set on invalid or insufficient status");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && res_valid && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");
`endif

endmodule
